// File: rtl/core/sfrc_pkg.sv
package sfrc_pkg;

    // Build-time default for the number of 32-bit words in one frame.
    localparam int PAYLOAD_WORDS_DEF = 15;

    localparam logic [7:0] HEADER_BYTE_DEF = 8'hBB;
    localparam logic [7:0] FRAME_TYPE_DEF  = 8'h02;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_BYTE = 1'b0,
        CFG_FRAME_TYPE  = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_HDR1,
        ST_HDR2,
        ST_TYPE,
        ST_LEN,
        ST_PAYLOAD,
        ST_CSUM,
        ST_READ,
        ST_SEND,
        ST_ERR
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_sum;
        logic add_sum;
        logic start_payload;
        logic take_payload;
        logic clear_word;
        logic read_word;
        logic next_word;
        logic err_result;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hdr_match;
        logic type_match;
        logic len_match;
        logic payload_last;
        logic csum_match;
        logic word_last;
    } stat_t;

endpackage

// File: rtl/core/sfrc_ifs.sv
interface sfrc_byte_if;
    logic                        valid;
    logic                        ready;
    logic [sfrc_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfrc_result_if;
    logic                                valid;
    logic                                ready;
    logic [sfrc_pkg::INDEX_W-1:0]        word_index;
    logic signed [sfrc_pkg::WORD_W-1:0]  word_value;
    logic                                frame_status;
    logic                                last;

    modport source (output valid, output word_index, output word_value,
                    output frame_status, output last, input ready);
    modport sink   (input valid, input word_index, input word_value,
                    input frame_status, input last, output ready);
endinterface

interface sfrc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sfrc_pkg::CFG_IDX_W-1:0] index;
    logic [sfrc_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/serial_frame_receiver_checksum_top.sv
// Serial frame receiver with checksum.
// rx carries one received byte per item. Frames are two header bytes, a type
// byte, a length byte equal to four times PAYLOAD_WORDS, the payload and a
// checksum byte that must equal the 8-bit sum of all earlier frame bytes.
// A byte that breaks the expected pattern sends the parser back to header
// hunting; that byte is dropped and not rechecked as a header.
// After a good checksum, res carries PAYLOAD_WORDS big-endian signed words
// in thousandths, last set on the final one; each word is first read from
// the word store (ST_READ) and then offered (ST_SEND). A bad checksum
// yields one result with frame_status set and last set, in the cycle after
// the checksum byte. rx.ready stays low for the whole burst.
// If the receiver holds res.ready low, the offered result waits unchanged.
// cfg writes header_byte (index 0) and frame_type (index 1); it is always
// ready and should be written only while no frame is being parsed.
// Reset returns the parser to header hunting, sets header_byte to 0xBB and
// frame_type to 0x02. The word store needs no clearing: each frame fills it.
module serial_frame_receiver_checksum_top #(
    parameter int PAYLOAD_WORDS = sfrc_pkg::PAYLOAD_WORDS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    sfrc_byte_if.sink     rx,
    sfrc_result_if.source res,
    sfrc_cfg_if.sink      cfg
);

    sfrc_pkg::cmd_t  cmd;
    sfrc_pkg::stat_t stat;

    assign cfg.ready = 1'b1;

    sfrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .out_ready (res.ready),
        .stat      (stat),
        .in_ready  (rx.ready),
        .out_valid (res.valid),
        .cmd       (cmd)
    );

    sfrc_datapath #(
        .PAYLOAD_WORDS (PAYLOAD_WORDS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx.rx_byte),
        .cfg_write    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .cmd          (cmd),
        .stat         (stat),
        .word_index   (res.word_index),
        .word_value   (res.word_value),
        .frame_status (res.frame_status),
        .last         (res.last)
    );

endmodule

// File: rtl/core/sfrc_datapath.sv
module sfrc_datapath #(
    parameter int PAYLOAD_WORDS = sfrc_pkg::PAYLOAD_WORDS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [sfrc_pkg::BYTE_W-1:0]        rx_byte,
    input  logic                               cfg_write,
    input  logic [sfrc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfrc_pkg::BYTE_W-1:0]        cfg_data,
    input  sfrc_pkg::cmd_t                     cmd,
    output sfrc_pkg::stat_t                    stat,
    output logic [sfrc_pkg::INDEX_W-1:0]       word_index,
    output logic signed [sfrc_pkg::WORD_W-1:0] word_value,
    output logic                               frame_status,
    output logic                               last
);

    localparam int FRAME_LEN = 4 * PAYLOAD_WORDS;
    localparam int WIDX_W    = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;

    logic [7:0]                   header_reg, header_next;
    logic [7:0]                   type_reg, type_next;
    logic [7:0]                   sum_reg, sum_next;
    logic [7:0]                   pos_reg, pos_next;
    logic [23:0]                  shift_reg, shift_next;
    logic [WIDX_W-1:0]            word_reg, word_next;
    logic [sfrc_pkg::WORD_W-1:0]  rd_data_reg;
    logic [sfrc_pkg::WORD_W-1:0]  word_mem [PAYLOAD_WORDS];

    always_comb
    begin
        header_next = header_reg;
        type_next   = type_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                sfrc_pkg::CFG_HEADER_BYTE: header_next = cfg_data;
                sfrc_pkg::CFG_FRAME_TYPE:  type_next   = cfg_data;
                default:                   header_next = header_reg;
            endcase
        end
    end

    always_comb
    begin
        sum_next   = sum_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        word_next  = word_reg;
        if (cmd.load_sum)
            sum_next = rx_byte;
        else if (cmd.add_sum || cmd.take_payload)
            sum_next = 8'(sum_reg + rx_byte);
        if (cmd.start_payload)
            pos_next = '0;
        else if (cmd.take_payload)
        begin
            pos_next   = 8'(pos_reg + 8'd1);
            shift_next = {shift_reg[15:0], rx_byte};
        end
        if (cmd.clear_word)
            word_next = '0;
        else if (cmd.next_word)
            word_next = WIDX_W'(word_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= sfrc_pkg::HEADER_BYTE_DEF;
            type_reg   <= sfrc_pkg::FRAME_TYPE_DEF;
            sum_reg    <= '0;
            pos_reg    <= '0;
            word_reg   <= '0;
        end
        else
        begin
            header_reg <= header_next;
            type_reg   <= type_next;
            sum_reg    <= sum_next;
            pos_reg    <= pos_next;
            word_reg   <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    // The fourth byte of each word completes it and writes the word store.
    always_ff @(posedge clk)
    begin
        if (cmd.take_payload && (pos_reg[1:0] == 2'b11))
            word_mem[pos_reg[WIDX_W+1:2]] <= {shift_reg, rx_byte};
        if (cmd.read_word)
            rd_data_reg <= word_mem[word_reg];
    end

    assign stat.hdr_match    = (rx_byte == header_reg);
    assign stat.type_match   = (rx_byte == type_reg);
    assign stat.len_match    = (rx_byte == 8'(FRAME_LEN));
    assign stat.payload_last = (pos_reg == 8'(FRAME_LEN - 1));
    assign stat.csum_match   = (rx_byte == sum_reg);
    assign stat.word_last    = (word_reg == WIDX_W'(PAYLOAD_WORDS - 1));

    assign word_index   = cmd.err_result ? '0 : sfrc_pkg::INDEX_W'(word_reg);
    assign word_value   = cmd.err_result ? '0 : $signed(rd_data_reg);
    assign frame_status = cmd.err_result;
    assign last         = cmd.err_result | stat.word_last;

endmodule

// File: rtl/core/sfrc_ctrl.sv
module sfrc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            out_ready,
    input  sfrc_pkg::stat_t stat,
    output logic            in_ready,
    output logic            out_valid,
    output sfrc_pkg::cmd_t  cmd
);

    sfrc_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfrc_pkg::ST_HDR1:
                if (in_valid && stat.hdr_match)
                    state_next = sfrc_pkg::ST_HDR2;
            sfrc_pkg::ST_HDR2:
                if (in_valid)
                    state_next = stat.hdr_match ? sfrc_pkg::ST_TYPE : sfrc_pkg::ST_HDR1;
            sfrc_pkg::ST_TYPE:
                if (in_valid)
                    state_next = stat.type_match ? sfrc_pkg::ST_LEN : sfrc_pkg::ST_HDR1;
            sfrc_pkg::ST_LEN:
                if (in_valid)
                    state_next = stat.len_match ? sfrc_pkg::ST_PAYLOAD : sfrc_pkg::ST_HDR1;
            sfrc_pkg::ST_PAYLOAD:
                if (in_valid && stat.payload_last)
                    state_next = sfrc_pkg::ST_CSUM;
            sfrc_pkg::ST_CSUM:
                if (in_valid)
                    state_next = stat.csum_match ? sfrc_pkg::ST_READ : sfrc_pkg::ST_ERR;
            sfrc_pkg::ST_READ:
                state_next = sfrc_pkg::ST_SEND;
            sfrc_pkg::ST_SEND:
                if (out_ready)
                    state_next = stat.word_last ? sfrc_pkg::ST_HDR1 : sfrc_pkg::ST_READ;
            sfrc_pkg::ST_ERR:
                if (out_ready)
                    state_next = sfrc_pkg::ST_HDR1;
            default:
                state_next = sfrc_pkg::ST_HDR1;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        case (state_reg)
            sfrc_pkg::ST_HDR1:
            begin
                in_ready     = 1'b1;
                cmd.load_sum = in_valid && stat.hdr_match;
            end
            sfrc_pkg::ST_HDR2:
            begin
                in_ready    = 1'b1;
                cmd.add_sum = in_valid && stat.hdr_match;
            end
            sfrc_pkg::ST_TYPE:
            begin
                in_ready    = 1'b1;
                cmd.add_sum = in_valid && stat.type_match;
            end
            sfrc_pkg::ST_LEN:
            begin
                in_ready          = 1'b1;
                cmd.add_sum       = in_valid && stat.len_match;
                cmd.start_payload = in_valid && stat.len_match;
            end
            sfrc_pkg::ST_PAYLOAD:
            begin
                in_ready         = 1'b1;
                cmd.take_payload = in_valid;
            end
            sfrc_pkg::ST_CSUM:
            begin
                in_ready       = 1'b1;
                cmd.clear_word = in_valid && stat.csum_match;
            end
            sfrc_pkg::ST_READ:
                cmd.read_word = 1'b1;
            sfrc_pkg::ST_SEND:
            begin
                out_valid     = 1'b1;
                cmd.next_word = out_ready;
            end
            sfrc_pkg::ST_ERR:
            begin
                out_valid      = 1'b1;
                cmd.err_result = 1'b1;
            end
            default:
                in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sfrc_pkg::ST_HDR1;
        else
            state_reg <= state_next;
    end

`ifndef ASSERT_OFF
    // The parser never takes a byte while a result is offered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while a result is pending");

    // A wrong checksum leads to exactly the error result.
    a_bad_csum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfrc_pkg::ST_CSUM && in_valid && !stat.csum_match)
        |=> (state_reg == sfrc_pkg::ST_ERR))
        else $error("checksum mismatch did not raise the error result");

    // After the last word is taken the parser hunts for a header again.
    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfrc_pkg::ST_SEND && out_ready && stat.word_last)
        |=> (state_reg == sfrc_pkg::ST_HDR1))
        else $error("word burst did not end after the last word");

    // Every word offered was read from the store in the cycle before.
    a_read_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && !cmd.err_result |-> $past(cmd.read_word))
        else $error("word offered without a store read");
`endif

endmodule

// File: test/tb_serial_frame_receiver_checksum_top.sv
module tb_serial_frame_receiver_checksum_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORDS = sfrc_pkg::PAYLOAD_WORDS_DEF;
    localparam int BODY_LEN = 4 * WORDS;
    localparam int POS_W = $clog2(BODY_LEN);
    localparam logic [7:0] LEN_BYTE = 8'(BODY_LEN);
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_BYTES = 180;
    localparam int PHASE_BYTES = 72;
    localparam int DIR_ROWS = 15;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_TYPE,
        PH_LEN,
        PH_BODY,
        PH_SUM
    } parse_phase_t;

    typedef struct packed {
        logic [3:0]  idx;
        logic [31:0] value;
        logic        status;
        logic        last;
    } word_res_t;

    typedef enum logic [0:0] {
        ROW_BYTE,
        ROW_FRAME
    } row_kind_t;

    // A frame row with typed set uses the word pattern {hi, lo, lo, lo} and
    // carries its expectation in the row; other frame rows use a byte ramp.
    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] b;
        logic [7:0] hi;
        logic [7:0] lo;
        logic       bad_sum;
        logic       typed;
    } dir_row_t;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_FRAME, 8'h00, 8'h7F, 8'hFF, 1'b0, 1'b1},
        '{ROW_FRAME, 8'h00, 8'h80, 8'h00, 1'b0, 1'b1},
        '{ROW_FRAME, 8'h00, 8'h12, 8'h34, 1'b1, 1'b1},
        '{ROW_BYTE,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  8'hFF, 8'h00, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  8'hBB, 8'h00, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  8'h3C, 8'h00, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  8'hBB, 8'h00, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  8'hBB, 8'h00, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  8'hBB, 8'h00, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  8'h02, 8'h00, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  8'hBB, 8'h00, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  8'hBB, 8'h00, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  8'h02, 8'h00, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  8'h3B, 8'h00, 8'h00, 1'b0, 1'b0}
    };

    // Header byte in the upper half, frame type in the lower half.
    logic [15:0] cfg_plan [4] = '{16'h00FF, 16'hFF00, 16'h3C3C, 16'hBB02};

    logic clk;
    logic rst_n;

    sfrc_byte_if   rx();
    sfrc_result_if res();
    sfrc_cfg_if    cfg();

    serial_frame_receiver_checksum_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res),
        .cfg   (cfg)
    );

    // Predictor state and register copies.
    parse_phase_t phase_now;
    logic [7:0]   hdr_cfg;
    logic [7:0]   type_cfg;
    logic [7:0]   body_left;
    logic [7:0]   body_pos;
    logic [7:0]   run_sum;
    logic [7:0]   body_bytes [BODY_LEN];

    word_res_t decoded_words [$];
    word_res_t expected_words [$];
    word_res_t typed_words [$];
    word_res_t head_word;
    logic [7:0] tx_body [BODY_LEN];

    int burst_left = 0;
    int rx_count = 0;
    int words_taken = 0;
    int fail_count = 0;
    int stall_cycles = 0;
    logic held = 1'b0;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic void reset_predictor();
        phase_now = PH_HDR1;
        hdr_cfg = sfrc_pkg::HEADER_BYTE_DEF;
        type_cfg = sfrc_pkg::FRAME_TYPE_DEF;
        body_left = '0;
        body_pos = '0;
        run_sum = '0;
        foreach (body_bytes[i])
            body_bytes[i] = '0;
    endfunction

    // Advances the parser by one byte and appends the words it releases.
    function automatic void decode_byte(input logic [7:0] b);
        word_res_t w;
        case (phase_now)
            PH_HDR1:
                if (b == hdr_cfg)
                begin
                    phase_now = PH_HDR2;
                    run_sum = b;
                end
            PH_HDR2:
                if (b == hdr_cfg)
                begin
                    phase_now = PH_TYPE;
                    run_sum = run_sum + b;
                end
                else
                    phase_now = PH_HDR1;
            PH_TYPE:
                if (b == type_cfg)
                begin
                    phase_now = PH_LEN;
                    run_sum = run_sum + b;
                end
                else
                    phase_now = PH_HDR1;
            PH_LEN:
                if (b == LEN_BYTE)
                begin
                    phase_now = PH_BODY;
                    run_sum = run_sum + b;
                    body_left = LEN_BYTE;
                    body_pos = '0;
                end
                else
                    phase_now = PH_HDR1;
            PH_BODY:
                if (body_left != 0)
                begin
                    if (body_pos < BODY_LEN)
                        body_bytes[body_pos[POS_W-1:0]] = b;
                    body_pos = body_pos + 8'd1;
                    body_left = body_left - 8'd1;
                    run_sum = run_sum + b;
                    if (body_left == 0)
                        phase_now = PH_SUM;
                end
                else
                    phase_now = PH_HDR1;
            PH_SUM:
            begin
                phase_now = PH_HDR1;
                if (b == run_sum)
                begin
                    for (int k = 0; k < WORDS; k++)
                    begin
                        w.idx = 4'(k);
                        w.value = {body_bytes[4*k], body_bytes[4*k+1],
                                   body_bytes[4*k+2], body_bytes[4*k+3]};
                        w.status = 1'b0;
                        w.last = (k == WORDS - 1);
                        decoded_words.push_back(w);
                    end
                end
                else
                    decoded_words.push_back('{idx: 4'd0, value: 32'd0,
                                              status: 1'b1, last: 1'b1});
            end
            default:
                phase_now = PH_HDR1;
        endcase
    endfunction

    // Entered and left at a falling edge; valid is left high so that the
    // next item of a burst follows without a gap.
    task automatic send_rx(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            rx.valid <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
        end
        rx.valid <= 1'b1;
        rx.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx.ready);
        decoded_words.delete();
        decode_byte(b);
        if (decoded_words.size() > 0)
        begin
            if (typed_words.size() > 0)
            begin
                foreach (typed_words[i])
                    expected_words.push_back(typed_words[i]);
                typed_words.delete();
            end
            else
                foreach (decoded_words[i])
                    expected_words.push_back(decoded_words[i]);
        end
        burst_left--;
        rx_count++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] sum_flip);
        logic [7:0] s;
        s = hdr_cfg + hdr_cfg + type_cfg + LEN_BYTE;
        foreach (tx_body[i])
            s = s + tx_body[i];
        send_rx(hdr_cfg);
        send_rx(hdr_cfg);
        send_rx(type_cfg);
        send_rx(LEN_BYTE);
        foreach (tx_body[i])
            send_rx(tx_body[i]);
        send_rx(s ^ sum_flip);
    endtask

    // Feeds bytes until the parser hunts for a header again, then waits
    // until every word has come out and the block has gone quiet.
    task automatic settle_parser();
        logic [7:0] b;
        while (phase_now != PH_HDR1)
        begin
            case (phase_now)
                PH_HDR2: b = hdr_cfg ^ 8'h01;
                PH_TYPE: b = type_cfg ^ 8'h01;
                PH_LEN:  b = LEN_BYTE ^ 8'h01;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_rx(b);
        end
        rx.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_config(input logic [7:0] h, input logic [7:0] t);
        cfg.valid <= 1'b1;
        cfg.index <= sfrc_pkg::CFG_HEADER_BYTE;
        cfg.data <= h;
        do
            @(posedge clk);
        while (!cfg.ready);
        hdr_cfg = h;
        @(negedge clk);
        cfg.index <= sfrc_pkg::CFG_FRAME_TYPE;
        cfg.data <= t;
        do
            @(posedge clk);
        while (!cfg.ready);
        type_cfg = t;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Mostly whole frames with random content, the rest broken headers and noise.
    task automatic send_random_sequence();
        int pick;
        int k;
        logic [7:0] due;
        logic [7:0] b;
        logic extreme;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            extreme = ($urandom_range(0, 9) == 0);
            foreach (tx_body[i])
            begin
                if (extreme)
                    case ($urandom_range(0, 3))
                        0: tx_body[i] = 8'h00;
                        1: tx_body[i] = 8'hFF;
                        2: tx_body[i] = 8'h7F;
                        default: tx_body[i] = 8'h80;
                    endcase
                else
                    tx_body[i] = 8'($urandom_range(0, 255));
            end
            send_frame(8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : 0));
        end
        else if (pick < 80)
        begin
            k = $urandom_range(1, 3);
            for (int p = 0; p <= k; p++)
            begin
                case (p)
                    0, 1: due = hdr_cfg;
                    2: due = type_cfg;
                    default: due = LEN_BYTE;
                endcase
                if (p < k)
                    send_rx(due);
                else
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == due);
                    send_rx(b);
                end
            end
        end
        else
        begin
            k = $urandom_range(1, 6);
            repeat (k) send_rx(8'($urandom_range(0, 255)));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            words_taken++;
            if (expected_words.size() == 0)
            begin
                fail_count++;
                $display("%0t ns: result with nothing expected: index %0d value %0d status %0b last %0b",
                         $time, res.word_index, $signed(res.word_value), res.frame_status,
                         res.last);
            end
            else
            begin
                head_word = expected_words.pop_front();
                if (res.word_index !== head_word.idx || res.word_value !== head_word.value ||
                    res.frame_status !== head_word.status || res.last !== head_word.last)
                begin
                    fail_count++;
                    $display("%0t ns: expected index %0d value %0d status %0b last %0b",
                             $time, head_word.idx, $signed(head_word.value), head_word.status,
                             head_word.last);
                    $display("%0t ns:   actual index %0d value %0d status %0b last %0b",
                             $time, res.word_index, $signed(res.word_value), res.frame_status,
                             res.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (rx.valid && rx.ready) || (res.valid && res.ready) ||
            (cfg.valid && cfg.ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // The receiver changes its stall pattern after each segment of random
    // length. Once, during the word burst of the second good frame, it holds off
    // long enough to stall the input.
    initial
    begin
        int seg_mode;
        int seg_len;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            seg_mode = $urandom_range(0, 2);
            seg_len = $urandom_range(10, 120);
            repeat (seg_len)
            begin
                @(negedge clk);
                if (!held && words_taken >= WORDS && res.valid)
                begin
                    held = 1'b1;
                    res.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                else
                    case (seg_mode)
                        0: res.ready <= 1'b1;
                        1: res.ready <= 1'($urandom_range(0, 1));
                        default: res.ready <= ($urandom_range(0, 3) == 0);
                    endcase
            end
        end
    end

    initial
    begin
        int phase_no;
        int phase_start;
        int rand_bytes0;
        dir_row_t row;
        rx.valid = 1'b0;
        rx.rx_byte = '0;
        cfg.valid = 1'b0;
        cfg.index = sfrc_pkg::CFG_HEADER_BYTE;
        cfg.data = '0;
        rst_n = 1'b0;
        reset_predictor();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            if (row.kind == ROW_BYTE)
                send_rx(row.b);
            else
            begin
                foreach (tx_body[j])
                    if (row.typed)
                        tx_body[j] = (j % 4 == 0) ? row.hi : row.lo;
                    else
                        tx_body[j] = 8'(row.hi + j * row.lo);
                if (row.typed && row.bad_sum)
                    typed_words.push_back('{idx: 4'd0, value: 32'd0, status: 1'b1, last: 1'b1});
                else if (row.typed)
                    for (int k = 0; k < WORDS; k++)
                        typed_words.push_back('{idx: 4'(k),
                                                value: {row.hi, row.lo, row.lo, row.lo},
                                                status: 1'b0, last: (k == WORDS - 1)});
                send_frame(row.bad_sum ? 8'h01 : 8'h00);
            end
        end

        rand_bytes0 = rx_count;
        phase_no = 0;
        while (rx_count - rand_bytes0 < RANDOM_BYTES)
        begin
            settle_parser();
            if (phase_no < 4)
                write_config(cfg_plan[phase_no][15:8], cfg_plan[phase_no][7:0]);
            else
                write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            phase_no++;
            phase_start = rx_count;
            while (rx_count - phase_start < PHASE_BYTES)
                send_random_sequence();
        end

        settle_parser();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
